FILE: rtl/assert_macros.svh
// Assertion macros shared by the timer table RTL.
// Include-guarded; used by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property must hold on every clock edge when out of reset.
`define CHK_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/dttt_pkg.sv
// Package for the delayed task timer table: widths, opcodes, result and command types.
// No dependencies.
`default_nettype none
package dttt_pkg;
    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 48;
    localparam int ID_BITS   = 8;
    localparam int IDX_BITS  = $clog2(SLOTS);
    localparam int CNT_BITS  = $clog2(SLOTS + 1);

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_SCHED = 3'd1;
    localparam logic [2:0] OP_CANCEL = 3'd2;
    localparam logic [2:0] OP_QUERY = 3'd3;
    localparam logic [2:0] OP_POLL  = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef struct packed {
        logic [7:0] result_id;
        logic       id_valid;
        logic       hit;
        logic       full_res;
        logic [4:0] pending;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  task_id;
        logic [31:0] wait_ms;
    } t_cmd;
endpackage
`default_nettype wire

FILE: rtl/dttt_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; payload type is given by the instantiator.
`default_nettype none
interface dttt_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/dttt_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module dttt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/delayed_task_timer_table.sv
// Tick/clear go straight to the result. Cancel/query walk the table through the
// RAM read port, reading then acting on each entry. A schedule that inserts
// walks, then shifts entries up one entry per cycle to free slot 0. Poll walks
// twice (count, then compact), and stalls while each due id waits to be taken.
// One command at a time; the next is taken once the last result is taken.
// Reset: time counter zero, table empty; RAM contents left as is.
`default_nettype none
`include "assert_macros.svh"
module delayed_task_timer_table (
    input wire logic i_clk,
    input wire logic i_rst_n,
    dttt_if.sink     i_cmd,
    dttt_if.source   o_res
);
    localparam int IB = dttt_pkg::IDX_BITS;
    localparam int CB = dttt_pkg::CNT_BITS;
    localparam int TB = dttt_pkg::TIME_BITS;
    localparam int EW = dttt_pkg::ID_BITS + TB;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;  // read address issued
    localparam logic [2:0] S_EX   = 3'd2;  // data back, act on entry
    localparam logic [2:0] S_INS  = 3'd3;  // shift up for insert
    localparam logic [2:0] S_OUT  = 3'd4;  // final result waiting
    localparam logic [2:0] S_PEM  = 3'd5;  // poll id waiting, walk resumes once taken

    logic [2:0]    r_st, n_st;
    logic [TB-1:0] r_now;
    logic [CB-1:0] r_cnt;
    logic [2:0]    r_op;
    logic [dttt_pkg::ID_BITS-1:0] r_id;
    logic [TB-1:0] r_due;
    logic [CB-1:0] r_rp, r_wp;   // read / write pointers (compaction)
    logic          r_found, r_pfound;  // r_pfound: poll in its compaction pass
    logic          r_ov;
    logic [CB-1:0] r_left;       // poll: due entries counted / still to emit
    dttt_pkg::t_result r_res;

    logic          we;
    logic [IB-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    dttt_ram #(.DEPTH(dttt_pkg::SLOTS), .WIDTH(EW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [dttt_pkg::ID_BITS-1:0] e_id;
    logic [TB-1:0] e_due;
    logic          e_isdue;
    logic [TB-1:0] head;
    logic [TB-1:0] dly;
    logic [CB-1:0] p_tot;
    assign e_id    = rdata[EW-1:TB];
    assign e_due   = rdata[TB-1:0];
    assign e_isdue = r_now >= e_due;
    assign head    = dttt_pkg::TIME_MAX - r_now;
    assign dly     = i_cmd.data.wait_ms[31] ? '0 : TB'(i_cmd.data.wait_ms);
    assign p_tot   = r_left + CB'(e_isdue);

    assign i_cmd.ready = (r_st == S_IDLE) && !o_res.valid;
    assign o_res.valid = (r_st == S_OUT) || (r_st == S_PEM);
    assign o_res.data  = r_res;

    logic acc;
    assign acc = i_cmd.valid && i_cmd.ready;

    logic res_last_fire;
    assign res_last_fire = o_res.valid && o_res.ready && o_res.data.last;

    always_comb begin
        n_st  = r_st;
        we    = 1'b0;
        waddr = r_wp[IB-1:0];
        wdata = {r_id, r_due};
        raddr = r_rp[IB-1:0];
        unique case (r_st)
            S_EX: begin
                priority if (r_op == dttt_pkg::OP_SCHED) begin
                    if (e_id == r_id) begin
                        we = 1'b1; waddr = r_rp[IB-1:0];
                    end
                end else if (r_op == dttt_pkg::OP_CANCEL) begin
                    we = r_found && !(e_id == r_id && !r_found);
                    wdata = rdata;
                end else if (r_op == dttt_pkg::OP_POLL) begin
                    we = r_pfound && !e_isdue; wdata = rdata;
                end else begin
                    we = 1'b0;
                end
            end
            S_INS: begin
                // read one below the entry being moved, ready for next cycle
                raddr = IB'(r_rp - CB'(1));
                we = 1'b1;
                if (r_ov) begin
                    waddr = '0; wdata = {r_id, r_due};
                end else begin
                    waddr = IB'(r_rp + CB'(1));
                    wdata = rdata;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_now <= '0;
            r_cnt <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: if (acc) begin
                    r_op  <= i_cmd.data.opcode;
                    r_id  <= i_cmd.data.task_id[dttt_pkg::ID_BITS-1:0];
                    r_due <= (dly > head) ? dttt_pkg::TIME_MAX : r_now + dly;
                    r_rp  <= '0; r_wp <= '0;
                    r_found <= 1'b0; r_pfound <= 1'b0; r_ov <= 1'b0;
                    r_left <= '0;
                    r_res.result_id <= i_cmd.data.task_id;
                    r_res.id_valid <= 1'b0; r_res.hit <= 1'b0;
                    r_res.full_res <= 1'b0; r_res.last <= 1'b1;
                    r_res.pending <= 5'(r_cnt);
                    if (i_cmd.data.opcode == dttt_pkg::OP_TICK) begin
                        if (r_now != dttt_pkg::TIME_MAX) r_now <= r_now + TB'(1);
                        r_st <= S_OUT;
                    end else if (i_cmd.data.opcode == dttt_pkg::OP_CLEAR) begin
                        r_cnt <= '0; r_res.pending <= '0; r_st <= S_OUT;
                    end else if (i_cmd.data.opcode >= dttt_pkg::OP_SCHED &&
                                 i_cmd.data.opcode <= dttt_pkg::OP_POLL &&
                                 r_cnt != '0) begin
                        r_st <= S_RD;
                    end else if (i_cmd.data.opcode == dttt_pkg::OP_SCHED) begin
                        // empty table: write at slot 0 via insert path
                        r_ov <= 1'b1; r_st <= S_INS;
                        r_cnt <= r_cnt + CB'(1);
                        r_res.pending <= 5'(r_cnt + CB'(1));
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_RD: r_st <= S_EX;
                S_EX: begin
                    r_st <= S_RD;
                    priority if (r_op == dttt_pkg::OP_SCHED) begin
                        if (e_id == r_id) begin
                            r_res.hit <= 1'b1; r_st <= S_OUT;
                        end else if (r_rp + CB'(1) == r_cnt) begin
                            if (r_cnt == CB'(dttt_pkg::SLOTS)) begin
                                r_res.full_res <= 1'b1; r_st <= S_OUT;
                            end else begin
                                r_st <= S_INS;
                                r_cnt <= r_cnt + CB'(1);
                                r_res.pending <= 5'(r_cnt + CB'(1));
                            end
                        end else r_rp <= r_rp + CB'(1);
                    end else if (r_op == dttt_pkg::OP_QUERY) begin
                        if (e_id == r_id) begin
                            r_res.hit <= e_isdue; r_st <= S_OUT;
                        end else if (r_rp + CB'(1) == r_cnt) r_st <= S_OUT;
                        else r_rp <= r_rp + CB'(1);
                    end else if (r_op == dttt_pkg::OP_CANCEL) begin
                        if (r_found || e_id != r_id) r_wp <= r_wp + CB'(1);
                        if (!r_found && e_id == r_id) r_found <= 1'b1;
                        r_rp <= r_rp + CB'(1);
                        if (r_rp + CB'(1) == r_cnt) begin
                            r_st <= S_OUT;
                            if (r_found || e_id == r_id) begin
                                r_res.hit <= 1'b1;
                                r_cnt <= r_cnt - CB'(1);
                                r_res.pending <= 5'(r_cnt - CB'(1));
                            end
                        end
                    end else if (!r_pfound) begin
                        // poll, first pass: count due entries only
                        r_rp <= r_rp + CB'(1);
                        if (e_isdue) r_left <= r_left + CB'(1);
                        if (r_rp + CB'(1) == r_cnt) begin
                            if (p_tot == '0) begin
                                r_st <= S_OUT;
                            end else begin
                                r_pfound <= 1'b1;
                                r_rp <= '0; r_wp <= '0;
                                r_left <= p_tot;
                                r_res.pending <= 5'(r_cnt - p_tot);
                            end
                        end
                    end else begin
                        // poll, second pass: compact in place, emit due ids;
                        // the last due id is held until the walk ends
                        r_rp <= r_rp + CB'(1);
                        if (!e_isdue) r_wp <= r_wp + CB'(1);
                        if (e_isdue) begin
                            r_res.result_id <= 8'(e_id);
                            r_res.id_valid <= 1'b1;
                            r_left <= r_left - CB'(1);
                            r_res.last <= (r_left == CB'(1));
                        end
                        if (r_rp + CB'(1) == r_cnt) begin
                            r_cnt <= e_isdue ? r_wp : r_wp + CB'(1);
                            r_st <= S_OUT;
                        end else if (e_isdue && r_left != CB'(1)) begin
                            r_st <= S_PEM;
                        end
                    end
                end
                S_INS: begin
                    if (r_ov) r_st <= S_OUT;
                    else if (r_rp == '0) r_ov <= 1'b1;
                    else r_rp <= r_rp - CB'(1);
                end
                S_PEM: if (o_res.ready) r_st <= S_RD;
                S_OUT: if (o_res.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // Table entry count must not exceed table size.
    `CHK_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= CB'(dttt_pkg::SLOTS), "count overflow")
    `CHK_NEXT(a_ack_idle, i_clk, i_rst_n, res_last_fire, r_st == S_IDLE, "no return to idle")
    `CHK_ALWAYS(a_no_acc_busy, i_clk, i_rst_n, !(i_cmd.ready && o_res.valid), "accept while busy")
endmodule
`default_nettype wire

FILE: bench/tb_delayed_task_timer_table.sv
// Testbench for delayed_task_timer_table: directed and random timer commands,
// results checked against an in-bench model of the task table.
// Depends on dttt_pkg, dttt_if and the RTL top level.
`timescale 1ns / 100ps
module tb_delayed_task_timer_table;
    import dttt_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dttt_if #(.T(t_cmd))    cmd_if (i_clk);
    dttt_if #(.T(t_result)) res_if (i_clk);

    delayed_task_timer_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    always #4 i_clk = ~i_clk;

    localparam int WATCHDOG_LIMIT = 20000;

    // model state
    logic [TIME_BITS-1:0] clk_ms;
    logic [7:0]           tbl_id  [SLOTS];
    logic [TIME_BITS-1:0] tbl_due [SLOTS];
    int                   tbl_cnt;

    t_result expected_q [$];
    int      mismatches = 0;
    int      stray      = 0;
    bit      timed_out  = 0;
    int      idle_send  = 0;  // percent
    int      idle_recv  = 0;
    int      quiet_cycles = 0;

    task automatic drop_entry(input int pos);
        for (int i = pos; i + 1 < tbl_cnt; i++) begin
            tbl_id[i]  = tbl_id[i+1];
            tbl_due[i] = tbl_due[i+1];
        end
        tbl_cnt--;
    endtask

    task automatic predict_results(input t_cmd c);
        t_result r;
        int pos;
        int nfound;
        logic [31:0] dly;
        logic [TIME_BITS-1:0] due;
        int i;
        r = '0;
        r.result_id = c.task_id;
        r.last = 1'b1;
        pos = -1;
        for (i = 0; i < tbl_cnt; i++)
            if (pos < 0 && tbl_id[i] == c.task_id) pos = i;
        case (c.opcode)
            OP_TICK: if (clk_ms != TIME_MAX) clk_ms++;
            OP_SCHED: begin
                dly = c.wait_ms[31] ? 32'd0 : c.wait_ms;
                due = ({{(TIME_BITS-32){1'b0}}, dly} > TIME_MAX - clk_ms) ? TIME_MAX
                                                                         : clk_ms + dly;
                if (pos >= 0) begin
                    tbl_due[pos] = due;
                    r.hit = 1'b1;
                end else if (tbl_cnt >= SLOTS) begin
                    r.full_res = 1'b1;
                end else begin
                    for (i = tbl_cnt; i > 0; i--) begin
                        tbl_id[i]  = tbl_id[i-1];
                        tbl_due[i] = tbl_due[i-1];
                    end
                    tbl_id[0] = c.task_id;
                    tbl_due[0] = due;
                    tbl_cnt++;
                end
            end
            OP_CANCEL: if (pos >= 0) begin
                drop_entry(pos);
                r.hit = 1'b1;
            end
            OP_QUERY: r.hit = (pos >= 0) && (clk_ms >= tbl_due[pos]);
            OP_POLL: begin
                t_result ids [$];
                i = 0;
                while (i < tbl_cnt) begin
                    if (clk_ms >= tbl_due[i]) begin
                        r.result_id = tbl_id[i];
                        ids.push_back(r);
                        drop_entry(i);
                    end else i++;
                end
                nfound = ids.size();
                if (nfound > 0) begin
                    foreach (ids[k]) begin
                        ids[k].id_valid = 1'b1;
                        ids[k].pending  = tbl_cnt[4:0];
                        ids[k].last     = (k == nfound - 1);
                        expected_q.push_back(ids[k]);
                    end
                    return;
                end
            end
            OP_CLEAR: tbl_cnt = 0;
            default: ;
        endcase
        r.pending = tbl_cnt[4:0];
        expected_q.push_back(r);
    endtask

    // send one command, honouring the sender idle rate; valid stays up
    // between back-to-back transactions
    task automatic send_cmd(input logic [2:0] op, input logic [7:0] id,
                            input logic [31:0] dly);
        t_cmd c;
        c.opcode = op;
        c.task_id = id;
        c.wait_ms = dly;
        while ($urandom_range(99) < idle_send) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predict_results(c);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG_LIMIT && !timed_out) begin
                timed_out = 1;
                $display("TEST FAILED");
                $finish;
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_q.size() == 0) begin
                    stray++;
                    if (mismatches + stray <= 10)
                        $display("unexpected result %p", res_if.data);
                end else begin
                    t_result e;
                    e = expected_q.pop_front();
                    if (res_if.data !== e) begin
                        mismatches++;
                        if (mismatches + stray <= 10)
                            $display("mismatch: expected %p got %p", e, res_if.data);
                    end
                end
            end
        end
    end

    always @(negedge i_clk)
        res_if.ready <= ($urandom_range(99) >= idle_recv);

    task automatic test_directed();
        send_cmd(OP_POLL, 8'hA5, 32'd0);             // poll, empty table
        send_cmd(OP_SCHED, 8'h00, 32'h8000_0000);   // most negative delay
        send_cmd(OP_SCHED, 8'hFF, 32'h7FFF_FFFF);
        send_cmd(OP_SCHED, 8'h12, 32'hFFFF_FFFF);   // -1
        send_cmd(OP_SCHED, 8'h34, 32'd2);
        send_cmd(OP_QUERY, 8'h00, 32'd0);
        send_cmd(OP_QUERY, 8'hFF, 32'd0);
        send_cmd(OP_QUERY, 8'h77, 32'd0);
        send_cmd(OP_SCHED, 8'hFF, 32'd1);           // update in place
        send_cmd(OP_TICK, 8'h00, 32'd0);
        send_cmd(OP_POLL, 8'h55, 32'd0);
        send_cmd(OP_CANCEL, 8'h34, 32'd0);
        send_cmd(OP_CANCEL, 8'h34, 32'd0);
        send_cmd(3'd6, 8'hC3, 32'hFFFF_FFFF);       // unused opcodes
        send_cmd(3'd7, 8'h3C, 32'd0);
        for (int i = 0; i < 17; i++)                 // fill; the 17th id wraps to 8'h01 and updates it in place
            send_cmd(OP_SCHED, 8'(i * 16 + 1), 32'd0);
        send_cmd(OP_POLL, 8'h00, 32'd0);             // sixteen due at once
        send_cmd(OP_CLEAR, 8'hFF, 32'd0);
    endtask

    task automatic test_time_saturation();
        // schedule the largest positive delay once drained, then query it
        wait_drained();
        send_cmd(OP_SCHED, 8'h42, 32'h7FFF_FFFF);
        send_cmd(OP_QUERY, 8'h42, 32'd0);
        send_cmd(OP_CLEAR, 8'h00, 32'd0);
    endtask

    task automatic test_random(input int n_items);
        logic [2:0] op;
        logic [31:0] dly;
        for (int k = 0; k < n_items; k++) begin
            case ($urandom_range(9))
                0, 1, 2: op = OP_SCHED;
                3, 4:    op = OP_TICK;
                5:       op = OP_CANCEL;
                6:       op = OP_QUERY;
                7, 8:    op = OP_POLL;
                default: op = ($urandom_range(9) == 0) ? OP_CLEAR : 3'($urandom_range(7));
            endcase
            case ($urandom_range(3))
                0:       dly = $urandom;
                default: dly = $urandom_range(6);
            endcase
            send_cmd(op, 8'($urandom_range(1) ? $urandom_range(23) : $urandom), dly);
        end
    endtask

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        clk_ms = '0;
        tbl_cnt = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_time_saturation();
        test_random(70);
        wait_drained();
        idle_send = 72;
        test_random(70);
        idle_send = 0;
        idle_recv = 72;
        test_random(70);
        wait_drained();
        idle_send = 11;
        idle_recv = 11;
        test_random(70);
        idle_send = 0;
        idle_recv = 0;

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && stray == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
